/* src/ps2md_pkg.sv */
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and codes of the ps/2 mouse device responder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  // host command codes
  localparam logic [7:0] CmdReset       = 8'hFF;
  localparam logic [7:0] CmdResend      = 8'hFE;
  localparam logic [7:0] CmdSetDefaults = 8'hF6;
  localparam logic [7:0] CmdDisable     = 8'hF5;
  localparam logic [7:0] CmdEnable      = 8'hF4;
  localparam logic [7:0] CmdSetRate     = 8'hF3;
  localparam logic [7:0] CmdGetId       = 8'hF2;
  localparam logic [7:0] CmdSetRemote   = 8'hF0;
  localparam logic [7:0] CmdReadData    = 8'hEB;
  localparam logic [7:0] CmdSetStream   = 8'hEA;
  localparam logic [7:0] CmdStatus      = 8'hE9;
  localparam logic [7:0] CmdSetRes      = 8'hE8;
  localparam logic [7:0] CmdNone        = 8'h00;

  // device response codes
  localparam logic [7:0] RspAck      = 8'hFA;
  localparam logic [7:0] RspSelfTest = 8'hAA;
  localparam logic [7:0] RspStatus   = 8'hE6;
  localparam logic [7:0] RspId       = 8'h00;

  // pending argument codes
  localparam logic [1:0] ArgNone = 2'd0;
  localparam logic [1:0] ArgRate = 2'd1;
  localparam logic [1:0] ArgRes  = 2'd2;

  localparam logic [7:0] RateReset = 8'd20;

  localparam int unsigned QueueDepthDefault = 2;

  // one item's response, up to four bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            stream_on;
    logic            reports_on;
  } desc_t;

endpackage

/* src/ps2_mouse_device_responder.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_device_responder
// Device side of a ps/2 mouse: answers host bytes and motion items.
// ----------------------------------------------------------------------------
// the response is queued, then its first byte goes into the output register
// throughput: one item per cycle while the response queue has room; the
//   back end sends one byte per cycle while its output is popped or empty
// reset: async active low, mode stream, reports off, rate 20, queues empty
module ps2_mouse_device_responder #(
  parameter int unsigned QueueDepth = ps2md_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              command_i,
  input  logic [7:0]        host_byte_i,
  input  logic signed [8:0] move_x_i,
  input  logic signed [8:0] move_y_i,
  input  logic [2:0]        button_bits_i,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        tx_byte_o,
  output logic              last_byte_o,
  output logic              stream_on_o,
  output logic              reports_on_o
);

  ps2md_pkg::desc_t wdesc, rdesc;
  logic accept, dpush, dpop, qfull, qempty;

  assign full   = qfull;
  assign accept = push && !qfull;

  ps2md_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command_i),
    .host_byte_i   (host_byte_i),
    .move_x_i      (move_x_i),
    .move_y_i      (move_y_i),
    .button_bits_i (button_bits_i),
    .desc_o        (wdesc),
    .desc_push_o   (dpush)
  );

  ps2md_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (dpush),
    .wdata_i (wdesc),
    .rd_i    (dpop),
    .rdata_o (rdesc),
    .full_o  (qfull),
    .empty_o (qempty)
  );

  ps2md_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (rdesc),
    .head_valid_i (!qempty),
    .head_pop_o   (dpop),
    .pop          (pop),
    .empty        (empty),
    .tx_byte_o    (tx_byte_o),
    .last_byte_o  (last_byte_o),
    .stream_on_o  (stream_on_o),
    .reports_on_o (reports_on_o)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dpush && qfull))
    else $error("response queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dpop && qempty))
    else $error("response queue read while empty");

  a_motion_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i) |=> !qempty)
    else $error("motion item left no response");

endmodule

/* src/ps2md_front.sv */
// ----------------------------------------------------------------------------
// ps2md_front
// Decodes items, keeps the mouse state and builds each response.
// ----------------------------------------------------------------------------
module ps2md_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                command_i,
  input  logic [7:0]          host_byte_i,
  input  logic signed [8:0]   move_x_i,
  input  logic signed [8:0]   move_y_i,
  input  logic [2:0]          button_bits_i,
  output ps2md_pkg::desc_t    desc_o,
  output logic                desc_push_o
);

  logic       stream_q, stream_d;
  logic       report_q, report_d;
  logic [7:0] res_q, res_d;
  logic [7:0] rate_q, rate_d;
  logic [7:0] prev_q, prev_d;
  logic [1:0] arg_q, arg_d;
  logic [8:0] hx_q, hx_d;
  logic [8:0] hy_q, hy_d;
  logic [2:0] hb_q, hb_d;

  logic [7:0] eff;
  logic [8:0] ny;
  logic [7:0] pkt0;
  logic [2:0] nbytes;
  logic [3:0][7:0] bytes;

  always_comb begin
    stream_d = stream_q;
    report_d = report_q;
    res_d    = res_q;
    rate_d   = rate_q;
    prev_d   = prev_q;
    arg_d    = arg_q;
    hx_d     = hx_q;
    hy_d     = hy_q;
    hb_d     = hb_q;
    bytes    = '0;
    nbytes   = 3'd0;
    eff      = ps2md_pkg::CmdNone;

    if (command_i) begin
      hx_d = move_x_i;
      hy_d = move_y_i;
      hb_d = button_bits_i;
    end

    // packet from the held values after this item
    ny   = 9'd0 - hy_d;
    pkt0 = {2'b00, ny[8], hx_d[8], 1'b1, hb_d};

    if (command_i) begin
      bytes  = {8'h00, ny[7:0], hx_d[7:0], pkt0};
      nbytes = 3'd3;
    end else if (arg_q == ps2md_pkg::ArgRate || arg_q == ps2md_pkg::ArgRes) begin
      bytes[0] = ps2md_pkg::RspAck;
      nbytes   = 3'd1;
      if (arg_q == ps2md_pkg::ArgRate) begin
        rate_d = host_byte_i;
      end else begin
        res_d = host_byte_i;
      end
      arg_d = ps2md_pkg::ArgNone;
    end else begin
      arg_d = ps2md_pkg::ArgNone;
      if (host_byte_i == ps2md_pkg::CmdResend) begin
        eff = (prev_q == ps2md_pkg::CmdResend) ? ps2md_pkg::CmdNone : prev_q;
      end else begin
        eff    = host_byte_i;
        prev_d = host_byte_i;
      end
      bytes[0] = ps2md_pkg::RspAck;
      nbytes   = 3'd1;
      case (eff)
        ps2md_pkg::CmdReset: begin
          bytes[1] = ps2md_pkg::RspSelfTest;
          bytes[2] = 8'h00;
          nbytes   = 3'd3;
        end
        ps2md_pkg::CmdSetDefaults: stream_d = 1'b1;
        ps2md_pkg::CmdDisable:     report_d = 1'b0;
        ps2md_pkg::CmdEnable:      report_d = 1'b1;
        ps2md_pkg::CmdSetRate:     arg_d    = ps2md_pkg::ArgRate;
        ps2md_pkg::CmdGetId: begin
          bytes[1] = ps2md_pkg::RspId;
          nbytes   = 3'd2;
        end
        ps2md_pkg::CmdSetRemote:   stream_d = 1'b0;
        ps2md_pkg::CmdReadData: begin
          bytes[1] = pkt0;
          bytes[2] = hx_q[7:0];
          bytes[3] = ny[7:0];
          nbytes   = 3'd4;
        end
        ps2md_pkg::CmdSetStream:   stream_d = 1'b1;
        ps2md_pkg::CmdStatus: begin
          bytes[1] = ps2md_pkg::RspStatus;
          bytes[2] = res_q;
          bytes[3] = rate_q;
          nbytes   = 3'd4;
        end
        ps2md_pkg::CmdSetRes:      arg_d  = ps2md_pkg::ArgRes;
        ps2md_pkg::CmdNone:        nbytes = 3'd0;
        default: ;
      endcase
    end
  end

  assign desc_o.bytes      = bytes;
  assign desc_o.last_idx   = 2'(nbytes - 3'd1);
  assign desc_o.stream_on  = stream_d;
  assign desc_o.reports_on = report_d;
  assign desc_push_o       = accept_i && (nbytes != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q <= 1'b1;
      report_q <= 1'b0;
      res_q    <= 8'd0;
      rate_q   <= ps2md_pkg::RateReset;
      prev_q   <= ps2md_pkg::CmdNone;
      arg_q    <= ps2md_pkg::ArgNone;
      hx_q     <= 9'd0;
      hy_q     <= 9'd0;
      hb_q     <= 3'd0;
    end else if (accept_i) begin
      stream_q <= stream_d;
      report_q <= report_d;
      res_q    <= res_d;
      rate_q   <= rate_d;
      prev_q   <= prev_d;
      arg_q    <= arg_d;
      hx_q     <= hx_d;
      hy_q     <= hy_d;
      hb_q     <= hb_d;
    end
  end

endmodule

/* src/ps2md_fifo.sv */
// ----------------------------------------------------------------------------
// ps2md_fifo
// Short queue of responses between front and back.
// ----------------------------------------------------------------------------
module ps2md_fifo #(
  parameter int unsigned Depth = ps2md_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  ps2md_pkg::desc_t wdata_i,
  input  logic             rd_i,
  output ps2md_pkg::desc_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthC  = CW'(Depth);

  ps2md_pkg::desc_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
      end
      if (rd_i) begin
        rp_q <= (rp_q == LastPtr) ? '0 : rp_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/ps2md_back.sv */
// ----------------------------------------------------------------------------
// ps2md_back
// Sends a queued response byte by byte through an output register.
// ----------------------------------------------------------------------------
module ps2md_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ps2md_pkg::desc_t head_i,
  input  logic             head_valid_i,
  output logic             head_pop_o,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       tx_byte_o,
  output logic             last_byte_o,
  output logic             stream_on_o,
  output logic             reports_on_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] tx_q;
  logic       last_q, stream_q, report_q;
  logic       load, is_last;

  assign load       = head_valid_i && (!valid_q || pop);
  assign is_last    = (idx_q == head_i.last_idx);
  assign head_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_q     <= head_i.bytes[idx_q];
      last_q   <= is_last;
      stream_q <= head_i.stream_on;
      report_q <= head_i.reports_on;
    end
  end

  assign empty        = !valid_q;
  assign tx_byte_o    = tx_q;
  assign last_byte_o  = last_q;
  assign stream_on_o  = stream_q;
  assign reports_on_o = report_q;

endmodule
